// ----- rtl/core/rrwp_pkg.sv -----
`default_nettype none

package rrwp_pkg;

	localparam int ANGLE_STAGES_DEF = 16;
	localparam int AtanEntries = 24;

	localparam int CORDIC_XW = 34;
	localparam int CORDIC_ZW = 32;
	localparam logic signed [CORDIC_XW-1:0] CORDIC_GAIN = 34'sd652032874;

	localparam logic signed [CORDIC_ZW-1:0] ATAN_TURN [0:AtanEntries-1] = '{
		32'sd536870912, 32'sd316933406, 32'sd167458907, 32'sd85004756,
		32'sd42667331, 32'sd21354465, 32'sd10679838, 32'sd5340245,
		32'sd2670163, 32'sd1335087, 32'sd667544, 32'sd333772,
		32'sd166886, 32'sd83443, 32'sd41722, 32'sd20861,
		32'sd10430, 32'sd5215, 32'sd2608, 32'sd1304,
		32'sd652, 32'sd326, 32'sd163, 32'sd81
	};

	localparam logic [15:0] RANGE_MIN_RST = 16'd0;
	localparam logic [15:0] RANGE_MAX_RST = 16'd4000;
	localparam logic [15:0] MAX_AGE_RST = 16'd200;

	typedef enum logic [1:0] {
		REG_RANGE_MIN,
		REG_RANGE_MAX,
		REG_MAX_AGE
	} rrwp_reg_t;

	typedef enum logic [2:0] {
		SENSOR_FRONT,
		SENSOR_BACK,
		SENSOR_LEFT,
		SENSOR_RIGHT,
		SENSOR_UP
	} rrwp_sensor_t;

	typedef enum logic [1:0] {
		QUAD_0,
		QUAD_1,
		QUAD_2,
		QUAD_3
	} rrwp_quad_t;

	typedef struct packed {
		logic [2:0] id;
		logic signed [17:0] bx;
		logic signed [17:0] by;
		logic signed [23:0] wz;
		logic signed [23:0] vx;
		logic signed [23:0] vy;
		logic [31:0] now;
		rrwp_quad_t quad;
	} rrwp_carry_t;

endpackage

`default_nettype wire

// ----- rtl/core/rrwp_cordic.sv -----
`default_nettype none

module rrwp_cordic import rrwp_pkg::*; #(
	parameter int STAGES = ANGLE_STAGES_DEF
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic in_valid,
	output logic in_ready,
	input wire logic signed [CORDIC_ZW-1:0] z_in,
	input wire rrwp_carry_t carry_in,
	output logic out_valid,
	input wire logic out_ready,
	output logic signed [CORDIC_XW-1:0] x_out,
	output logic signed [CORDIC_XW-1:0] y_out,
	output rrwp_carry_t carry_out
);

	logic v_s [STAGES];
	logic en [STAGES+1];
	logic signed [CORDIC_XW-1:0] x_s [STAGES];
	logic signed [CORDIC_XW-1:0] y_s [STAGES];
	logic signed [CORDIC_ZW-1:0] z_s [STAGES];
	rrwp_carry_t c_s [STAGES];

	assign en[STAGES] = out_ready;

	for (genvar i = 0; i < STAGES; i++) begin : g_stage
		logic vp;
		logic signed [CORDIC_XW-1:0] xp, yp, xs, ys;
		logic signed [CORDIC_ZW-1:0] zp;
		rrwp_carry_t cp;

		if (i == 0) begin : g_first
			assign vp = in_valid;
			assign xp = CORDIC_GAIN;
			assign yp = '0;
			assign zp = z_in;
			assign cp = carry_in;
		end else begin : g_next
			assign vp = v_s[i-1];
			assign xp = x_s[i-1];
			assign yp = y_s[i-1];
			assign zp = z_s[i-1];
			assign cp = c_s[i-1];
		end

		assign xs = xp >>> i;
		assign ys = yp >>> i;
		assign en[i] = !v_s[i] || en[i+1];

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[i] <= 1'b0;
			end else if (en[i]) begin
				v_s[i] <= vp;
			end
		end

		always_ff @(posedge clk) begin
			if (en[i]) begin
				c_s[i] <= cp;
				if (!zp[CORDIC_ZW-1]) begin
					x_s[i] <= xp - ys;
					y_s[i] <= yp + xs;
					z_s[i] <= zp - ATAN_TURN[i];
				end else begin
					x_s[i] <= xp + ys;
					y_s[i] <= yp - xs;
					z_s[i] <= zp + ATAN_TURN[i];
				end
			end
		end
	end

	assign in_ready = en[0];
	assign out_valid = v_s[STAGES-1];
	assign x_out = x_s[STAGES-1];
	assign y_out = y_s[STAGES-1];
	assign carry_out = c_s[STAGES-1];

endmodule

`default_nettype wire

// ----- rtl/core/range_ray_to_world_point.sv -----
// Converts one range reading and the vehicle pose into an obstacle point in
// the world frame. Readings arrive on the in_valid/in_ready channel; each
// transfer carries the sensor id, range, mount offset, pose and times.
// A reading outside the range window, without a pose, with a stale pose or
// with an unknown sensor id is taken and dropped without a result. Other
// readings produce one point on the out_valid/out_ready channel.
// The datapath is a pipeline of ANGLE_STAGES + 5 registers: an input check
// stage, one stage per CORDIC iteration, then sin/cos rounding, the four
// rotation products, the rounded sums and the saturated output register.
// One reading is accepted every cycle unless every stage is occupied and
// the receiver stalls. Every stage has its own valid bit and is loaded
// whenever it is empty or its successor moves, so bubbles are squeezed out.
// When the receiver stalls, the output holds and the pipeline fills behind
// it; in_ready drops only when every stage is occupied.
// The three window registers are written through cfg_we/cfg_index/cfg_data,
// by the user only while the block is idle; the block does not enforce it.
// Reset clears all valid bits and loads the defaults (0 mm, 4000 mm, 200 ms).
`default_nettype none

module range_ray_to_world_point import rrwp_pkg::*; #(
	parameter int ANGLE_STAGES = ANGLE_STAGES_DEF
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic cfg_we,
	input wire logic [1:0] cfg_index,
	input wire logic [15:0] cfg_data,
	input wire logic in_valid,
	output logic in_ready,
	input wire logic [2:0] sensor_id,
	input wire logic [15:0] range_mm,
	input wire logic signed [15:0] mount_x_mm,
	input wire logic signed [15:0] mount_y_mm,
	input wire logic signed [15:0] mount_z_mm,
	input wire logic signed [23:0] vehicle_x_mm,
	input wire logic signed [23:0] vehicle_y_mm,
	input wire logic signed [23:0] vehicle_z_mm,
	input wire logic signed [15:0] heading,
	input wire logic pose_seen,
	input wire logic [31:0] now_ms,
	input wire logic [31:0] pose_time_ms,
	output logic out_valid,
	input wire logic out_ready,
	output logic [2:0] hit_sensor,
	output logic signed [23:0] hit_x_mm,
	output logic signed [23:0] hit_y_mm,
	output logic signed [23:0] hit_z_mm,
	output logic [31:0] hit_time_ms
);

	function automatic logic signed [23:0] sat24(input logic signed [24:0] v);
		if (v > 25'sd8388607) begin
			return 24'sd8388607;
		end else if (v < -25'sd8388608) begin
			return -24'sd8388608;
		end
		return v[23:0];
	endfunction

	function automatic logic signed [15:0] sat16(input logic signed [18:0] v);
		if (v > 19'sd32767) begin
			return 16'sd32767;
		end else if (v < -19'sd32768) begin
			return -16'sd32768;
		end
		return v[15:0];
	endfunction

	function automatic logic signed [15:0] neg16(input logic signed [15:0] v);
		if (v == -16'sd32768) begin
			return 16'sd32767;
		end
		return -v;
	endfunction

	logic [15:0] range_min_q, range_max_q, max_age_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			range_min_q <= RANGE_MIN_RST;
			range_max_q <= RANGE_MAX_RST;
			max_age_q <= MAX_AGE_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_RANGE_MIN: range_min_q <= cfg_data;
				REG_RANGE_MAX: range_max_q <= cfg_data;
				REG_MAX_AGE: max_age_q <= cfg_data;
				default: ;
			endcase
		end
	end

	logic en_s1, en_s2, en_s3, en_s4, en_s5;
	logic v_s1, v_s2, v_s3, v_s4, v_s5;
	logic cor_in_ready, cor_out_valid;

	assign en_s5 = !v_s5 || out_ready;
	assign en_s4 = !v_s4 || en_s5;
	assign en_s3 = !v_s3 || en_s4;
	assign en_s2 = !v_s2 || en_s3;
	assign en_s1 = !v_s1 || cor_in_ready;
	assign in_ready = en_s1;

	logic [31:0] age;
	logic age_ok, range_ok, id_ok, item_ok;
	logic [15:0] angle_off;
	logic [15:0] resid;
	rrwp_carry_t carry_d;
	logic signed [17:0] rng18;
	logic signed [17:0] mx18, my18;
	logic signed [17:0] bz;

	assign age = now_ms - pose_time_ms;
	assign age_ok = age[31] || (age[30:0] <= {15'd0, max_age_q});
	assign range_ok = (range_mm >= range_min_q) && (range_mm <= range_max_q);
	assign id_ok = sensor_id <= 3'(SENSOR_UP);
	assign item_ok = age_ok && range_ok && id_ok && pose_seen;

	assign angle_off = heading + 16'h2000;
	assign resid = heading - {angle_off[15:14], 14'd0};
	assign rng18 = {2'b00, range_mm};
	assign mx18 = 18'(mount_x_mm);
	assign my18 = 18'(mount_y_mm);

	always_comb begin
		carry_d.id = sensor_id;
		carry_d.bx = mx18;
		carry_d.by = my18;
		bz = 18'(mount_z_mm);
		case (sensor_id)
			SENSOR_FRONT: carry_d.bx = mx18 + rng18;
			SENSOR_BACK: carry_d.bx = mx18 - rng18;
			SENSOR_LEFT: carry_d.by = my18 + rng18;
			SENSOR_RIGHT: carry_d.by = my18 - rng18;
			default: bz = 18'(mount_z_mm) + rng18;
		endcase
		carry_d.wz = sat24(25'(vehicle_z_mm) + 25'(bz));
		carry_d.vx = vehicle_x_mm;
		carry_d.vy = vehicle_y_mm;
		carry_d.now = now_ms;
		carry_d.quad = rrwp_quad_t'(angle_off[15:14]);
	end

	rrwp_carry_t carry_s1;
	logic signed [CORDIC_ZW-1:0] z_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (en_s1) begin
			v_s1 <= in_valid && item_ok;
		end
	end

	always_ff @(posedge clk) begin
		if (en_s1) begin
			carry_s1 <= carry_d;
			z_s1 <= {resid, 16'd0};
		end
	end

	logic signed [CORDIC_XW-1:0] cor_x, cor_y;
	rrwp_carry_t cor_carry;

	rrwp_cordic #(
		.STAGES(ANGLE_STAGES)
	) u_cordic (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(v_s1),
		.in_ready(cor_in_ready),
		.z_in(z_s1),
		.carry_in(carry_s1),
		.out_valid(cor_out_valid),
		.out_ready(en_s2),
		.x_out(cor_x),
		.y_out(cor_y),
		.carry_out(cor_carry)
	);

	logic signed [CORDIC_XW-1:0] x_half, y_half;
	logic signed [15:0] c_rnd, s_rnd, cos_d, sin_d;

	assign x_half = cor_x + CORDIC_XW'(16384);
	assign y_half = cor_y + CORDIC_XW'(16384);
	assign c_rnd = sat16(19'(x_half >>> 15));
	assign s_rnd = sat16(19'(y_half >>> 15));

	always_comb begin
		case (cor_carry.quad)
			QUAD_0: begin
				cos_d = c_rnd;
				sin_d = s_rnd;
			end
			QUAD_1: begin
				cos_d = neg16(s_rnd);
				sin_d = c_rnd;
			end
			QUAD_2: begin
				cos_d = neg16(c_rnd);
				sin_d = neg16(s_rnd);
			end
			default: begin
				cos_d = s_rnd;
				sin_d = neg16(c_rnd);
			end
		endcase
	end

	rrwp_carry_t carry_s2, carry_s3, carry_s4;
	logic signed [15:0] cos_s2, sin_s2;
	logic signed [33:0] bxc_s3, bys_s3, bxs_s3, byc_s3;
	logic signed [19:0] rx_s4, ry_s4;
	logic signed [34:0] sum_x, sum_y;
	logic [2:0] id_s5;
	logic signed [23:0] x_s5, y_s5, z_s5;
	logic [31:0] now_s5;

	assign sum_x = 35'(bxc_s3) - 35'(bys_s3) + 35'sd16384;
	assign sum_y = 35'(bxs_s3) + 35'(byc_s3) + 35'sd16384;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else begin
			if (en_s2) begin
				v_s2 <= cor_out_valid;
			end
			if (en_s3) begin
				v_s3 <= v_s2;
			end
			if (en_s4) begin
				v_s4 <= v_s3;
			end
			if (en_s5) begin
				v_s5 <= v_s4;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en_s2) begin
			carry_s2 <= cor_carry;
			cos_s2 <= cos_d;
			sin_s2 <= sin_d;
		end
		if (en_s3) begin
			carry_s3 <= carry_s2;
			bxc_s3 <= 34'(carry_s2.bx) * 34'(cos_s2);
			bys_s3 <= 34'(carry_s2.by) * 34'(sin_s2);
			bxs_s3 <= 34'(carry_s2.bx) * 34'(sin_s2);
			byc_s3 <= 34'(carry_s2.by) * 34'(cos_s2);
		end
		if (en_s4) begin
			carry_s4 <= carry_s3;
			rx_s4 <= 20'(sum_x >>> 15);
			ry_s4 <= 20'(sum_y >>> 15);
		end
		if (en_s5) begin
			id_s5 <= carry_s4.id;
			x_s5 <= sat24(25'(carry_s4.vx) + 25'(rx_s4));
			y_s5 <= sat24(25'(carry_s4.vy) + 25'(ry_s4));
			z_s5 <= carry_s4.wz;
			now_s5 <= carry_s4.now;
		end
	end

	assign out_valid = v_s5;
	assign hit_sensor = id_s5;
	assign hit_x_mm = x_s5;
	assign hit_y_mm = y_s5;
	assign hit_z_mm = z_s5;
	assign hit_time_ms = now_s5;

`ifndef ASSERT_OFF
	a_ready_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!v_s5 |-> in_ready)
		else $error("input not ready while the output stage is empty");

	a_sensor_known: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (hit_sensor <= 3'(SENSOR_UP)))
		else $error("result carries an unknown sensor id");

	a_cordic_hold: assert property (@(posedge clk) disable iff (!arst_n)
		cor_out_valid && !en_s2 |=> cor_out_valid && $stable(cor_carry))
		else $error("stalled rotation result was lost or changed");
`endif

endmodule

`default_nettype wire

// ----- dv/world_point_checker.sv -----
`timescale 1ns / 100ps

module world_point_checker import rrwp_pkg::*; (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic cfg_we,
	input wire logic [1:0] cfg_index,
	input wire logic [15:0] cfg_data,
	input wire logic in_valid,
	input wire logic in_ready,
	input wire logic [2:0] sensor_id,
	input wire logic [15:0] range_mm,
	input wire logic signed [15:0] mount_x_mm,
	input wire logic signed [15:0] mount_y_mm,
	input wire logic signed [15:0] mount_z_mm,
	input wire logic signed [23:0] vehicle_x_mm,
	input wire logic signed [23:0] vehicle_y_mm,
	input wire logic signed [23:0] vehicle_z_mm,
	input wire logic signed [15:0] heading,
	input wire logic pose_seen,
	input wire logic [31:0] now_ms,
	input wire logic [31:0] pose_time_ms,
	input wire logic out_valid,
	input wire logic out_ready,
	input wire logic [2:0] hit_sensor,
	input wire logic signed [23:0] hit_x_mm,
	input wire logic signed [23:0] hit_y_mm,
	input wire logic signed [23:0] hit_z_mm,
	input wire logic [31:0] hit_time_ms,
	output int fail_count,
	output int pending,
	output int points_checked
);

	typedef struct packed {
		logic [2:0] sensor;
		logic signed [23:0] x;
		logic signed [23:0] y;
		logic signed [23:0] z;
		logic [31:0] stamp;
	} world_point_t;

	localparam longint POS_HI = 64'sd8388607;
	localparam longint POS_LO = -64'sd8388608;
	localparam longint TRIG_HI = 64'sd32767;
	localparam longint TRIG_LO = -64'sd32768;
	localparam int EXP_DEPTH = 64;

	logic [15:0] win_min;
	logic [15:0] win_max;
	logic [15:0] age_limit;
	world_point_t expected_points [EXP_DEPTH];
	int exp_head;
	int exp_tail;
	int exp_count;
	world_point_t predicted;
	world_point_t observed;
	world_point_t oldest;

	function automatic longint clamp(input longint v, input longint lo, input longint hi);
		return (v < lo) ? lo : ((v > hi) ? hi : v);
	endfunction

	// Returns 1 and the world point if the reading passes id, window, pose and
	// age checks; the heading goes through a quadrant fold and a CORDIC rotation.
	function automatic bit project_reading(
		input logic [2:0] sid,
		input logic [15:0] rng_mm,
		input logic signed [15:0] mx,
		input logic signed [15:0] my,
		input logic signed [15:0] mz,
		input logic signed [23:0] vx,
		input logic signed [23:0] vy,
		input logic signed [23:0] vz,
		input logic [15:0] hdg,
		input logic seen,
		input logic [31:0] now,
		input logic [31:0] ptime,
		output world_point_t pt
	);
		longint age, lim, r, bx, by, bz, x, y, z, xs, ys, c, s, cq, sq, wx, wy, wz;
		logic [31:0] age_bits;
		logic [15:0] shifted;
		logic [15:0] residual;
		rrwp_quad_t quad;
		int i;
		pt = '0;
		age_bits = now - ptime;
		age = $signed(age_bits);
		lim = age_limit;
		if (sid > 3'd4)
			return 1'b0;
		if (rng_mm < win_min || rng_mm > win_max)
			return 1'b0;
		if (!seen)
			return 1'b0;
		if (age > lim)
			return 1'b0;
		r = rng_mm;
		bx = mx;
		by = my;
		bz = mz;
		case (sid)
			SENSOR_FRONT: bx = bx + r;
			SENSOR_BACK: bx = bx - r;
			SENSOR_LEFT: by = by + r;
			SENSOR_RIGHT: by = by - r;
			default: bz = bz + r;
		endcase
		shifted = hdg + 16'h2000;
		quad = rrwp_quad_t'(shifted[15:14]);
		residual = hdg - {shifted[15:14], 14'b0};
		z = $signed(residual);
		z = z * 65536;
		x = CORDIC_GAIN;
		y = 0;
		for (i = 0; i < ANGLE_STAGES_DEF && i < AtanEntries; i++) begin
			xs = x >>> i;
			ys = y >>> i;
			if (z >= 0) begin
				x = x - ys;
				y = y + xs;
				z = z - ATAN_TURN[i];
			end else begin
				x = x + ys;
				y = y - xs;
				z = z + ATAN_TURN[i];
			end
		end
		cq = clamp((x + 16384) >>> 15, TRIG_LO, TRIG_HI);
		sq = clamp((y + 16384) >>> 15, TRIG_LO, TRIG_HI);
		case (quad)
			QUAD_0: begin
				c = cq;
				s = sq;
			end
			QUAD_1: begin
				c = clamp(-sq, TRIG_LO, TRIG_HI);
				s = cq;
			end
			QUAD_2: begin
				c = clamp(-cq, TRIG_LO, TRIG_HI);
				s = clamp(-sq, TRIG_LO, TRIG_HI);
			end
			default: begin
				c = sq;
				s = clamp(-cq, TRIG_LO, TRIG_HI);
			end
		endcase
		wx = clamp(longint'(vx) + ((bx * c - by * s + 16384) >>> 15), POS_LO, POS_HI);
		wy = clamp(longint'(vy) + ((bx * s + by * c + 16384) >>> 15), POS_LO, POS_HI);
		wz = clamp(longint'(vz) + bz, POS_LO, POS_HI);
		pt.sensor = sid;
		pt.x = wx[23:0];
		pt.y = wy[23:0];
		pt.z = wz[23:0];
		pt.stamp = now;
		return 1'b1;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			win_min <= RANGE_MIN_RST;
			win_max <= RANGE_MAX_RST;
			age_limit <= MAX_AGE_RST;
			exp_head = 0;
			exp_tail = 0;
			exp_count = 0;
			fail_count <= 0;
			pending <= 0;
			points_checked <= 0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					REG_RANGE_MIN: win_min <= cfg_data;
					REG_RANGE_MAX: win_max <= cfg_data;
					REG_MAX_AGE: age_limit <= cfg_data;
					default: ;
				endcase
			end
			if (out_valid && out_ready) begin
				observed = {hit_sensor, hit_x_mm, hit_y_mm, hit_z_mm, hit_time_ms};
				points_checked <= points_checked + 1;
				if (exp_count == 0) begin
					if (fail_count < 10)
						$display("Unexpected point: sensor %0d x %0d y %0d z %0d time %0d",
							observed.sensor, observed.x, observed.y, observed.z,
							observed.stamp);
					fail_count <= fail_count + 1;
				end else begin
					oldest = expected_points[exp_head];
					exp_head = (exp_head + 1) % EXP_DEPTH;
					exp_count = exp_count - 1;
					if (oldest.sensor !== observed.sensor || oldest.x !== observed.x ||
							oldest.y !== observed.y || oldest.z !== observed.z ||
							oldest.stamp !== observed.stamp) begin
						if (fail_count < 10)
							$display({"Point mismatch (expected/actual): sensor %0d/%0d ",
								"x %0d/%0d y %0d/%0d z %0d/%0d time %0d/%0d"},
								oldest.sensor, observed.sensor, oldest.x, observed.x,
								oldest.y, observed.y, oldest.z, observed.z,
								oldest.stamp, observed.stamp);
						fail_count <= fail_count + 1;
					end
				end
			end
			if (in_valid && in_ready) begin
				if (project_reading(sensor_id, range_mm, mount_x_mm, mount_y_mm, mount_z_mm,
						vehicle_x_mm, vehicle_y_mm, vehicle_z_mm, heading, pose_seen,
						now_ms, pose_time_ms, predicted)) begin
					expected_points[exp_tail] = predicted;
					exp_tail = (exp_tail + 1) % EXP_DEPTH;
					exp_count = exp_count + 1;
				end
			end
			pending <= exp_count;
		end
	end

endmodule

// ----- dv/tb_range_ray_to_world_point.sv -----
`timescale 1ns / 100ps

module tb_range_ray_to_world_point import rrwp_pkg::*; ();

	localparam int WATCHDOG_LIMIT = 2000;
	localparam int SETTLE_CYCLES = ANGLE_STAGES_DEF + 10;

	typedef struct packed {
		logic [2:0] sid;
		logic [15:0] dist_mm;
		logic signed [15:0] mx;
		logic signed [15:0] my;
		logic signed [15:0] mz;
		logic signed [23:0] vx;
		logic signed [23:0] vy;
		logic signed [23:0] vz;
		logic [15:0] hdg;
		logic seen;
		logic [31:0] now;
		logic [31:0] ptime;
	} reading_t;

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic [1:0] cfg_index;
	logic [15:0] cfg_data;
	logic in_valid;
	logic in_ready;
	logic [2:0] sensor_id;
	logic [15:0] range_mm;
	logic signed [15:0] mount_x_mm;
	logic signed [15:0] mount_y_mm;
	logic signed [15:0] mount_z_mm;
	logic signed [23:0] vehicle_x_mm;
	logic signed [23:0] vehicle_y_mm;
	logic signed [23:0] vehicle_z_mm;
	logic signed [15:0] heading;
	logic pose_seen;
	logic [31:0] now_ms;
	logic [31:0] pose_time_ms;
	logic out_valid;
	logic out_ready = 1'b0;
	logic [2:0] hit_sensor;
	logic signed [23:0] hit_x_mm;
	logic signed [23:0] hit_y_mm;
	logic signed [23:0] hit_z_mm;
	logic [31:0] hit_time_ms;

	int fail_count;
	int pending;
	int points_checked;
	int readings_sent = 0;
	int windows_run = 1;
	int stall_cycles = 0;
	bit idling_on = 1'b1;
	logic [15:0] cur_min = RANGE_MIN_RST;
	logic [15:0] cur_max = RANGE_MAX_RST;
	logic [15:0] cur_age = MAX_AGE_RST;

	range_ray_to_world_point #(.ANGLE_STAGES(ANGLE_STAGES_DEF)) u_dut (
		.clk(clk), .arst_n(arst_n),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.in_valid(in_valid), .in_ready(in_ready),
		.sensor_id(sensor_id), .range_mm(range_mm),
		.mount_x_mm(mount_x_mm), .mount_y_mm(mount_y_mm), .mount_z_mm(mount_z_mm),
		.vehicle_x_mm(vehicle_x_mm), .vehicle_y_mm(vehicle_y_mm),
		.vehicle_z_mm(vehicle_z_mm), .heading(heading), .pose_seen(pose_seen),
		.now_ms(now_ms), .pose_time_ms(pose_time_ms),
		.out_valid(out_valid), .out_ready(out_ready),
		.hit_sensor(hit_sensor), .hit_x_mm(hit_x_mm), .hit_y_mm(hit_y_mm),
		.hit_z_mm(hit_z_mm), .hit_time_ms(hit_time_ms)
	);

	world_point_checker u_checker (
		.clk(clk), .arst_n(arst_n),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.in_valid(in_valid), .in_ready(in_ready),
		.sensor_id(sensor_id), .range_mm(range_mm),
		.mount_x_mm(mount_x_mm), .mount_y_mm(mount_y_mm), .mount_z_mm(mount_z_mm),
		.vehicle_x_mm(vehicle_x_mm), .vehicle_y_mm(vehicle_y_mm),
		.vehicle_z_mm(vehicle_z_mm), .heading(heading), .pose_seen(pose_seen),
		.now_ms(now_ms), .pose_time_ms(pose_time_ms),
		.out_valid(out_valid), .out_ready(out_ready),
		.hit_sensor(hit_sensor), .hit_x_mm(hit_x_mm), .hit_y_mm(hit_y_mm),
		.hit_z_mm(hit_z_mm), .hit_time_ms(hit_time_ms),
		.fail_count(fail_count), .pending(pending), .points_checked(points_checked)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	always @(posedge clk) begin
		out_ready <= !idling_on || ($urandom_range(99) >= 16);
	end

	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready)) begin
			stall_cycles <= 0;
		end else if (stall_cycles >= WATCHDOG_LIMIT) begin
			$display("Watchdog expired after %0d cycles without a transfer.", stall_cycles);
			$display("FAILURE");
			$finish;
		end else begin
			stall_cycles <= stall_cycles + 1;
		end
	end

	function automatic reading_t nominal(input logic [2:0] sid, input logic [15:0] dist_in);
		reading_t rd;
		rd = '0;
		rd.sid = sid;
		rd.dist_mm = dist_in;
		rd.seen = 1'b1;
		rd.now = 32'd1000;
		rd.ptime = 32'd990;
		return rd;
	endfunction

	function automatic logic signed [15:0] rand_mount();
		if ($urandom_range(99) < 50)
			return 16'(int'($urandom_range(4000)) - 2000);
		return 16'($urandom);
	endfunction

	function automatic logic signed [23:0] rand_position();
		int pick;
		pick = $urandom_range(99);
		if (pick < 60)
			return 24'(int'($urandom_range(2000000)) - 1000000);
		if (pick < 85)
			return 24'($urandom);
		if (pick < 93)
			return 24'(8388607 - int'($urandom_range(3000)));
		return 24'(-8388608 + int'($urandom_range(3000)));
	endfunction

	// Mostly readings that pass the current window, pose and age checks, with
	// a share of stale, unseen, out-of-window and unknown-sensor readings.
	function automatic reading_t random_reading();
		reading_t rd;
		int pick;
		rd.sid = ($urandom_range(99) < 90) ? 3'($urandom_range(4)) : 3'($urandom_range(7, 5));
		pick = $urandom_range(99);
		if (pick < 65 && cur_min <= cur_max)
			rd.dist_mm = 16'($urandom_range(cur_max, cur_min));
		else if (pick < 80)
			rd.dist_mm = 16'($urandom);
		else begin
			case ($urandom_range(3))
				0: rd.dist_mm = cur_min;
				1: rd.dist_mm = cur_max;
				2: rd.dist_mm = cur_min - 16'd1;
				default: rd.dist_mm = cur_max + 16'd1;
			endcase
		end
		rd.mx = rand_mount();
		rd.my = rand_mount();
		rd.mz = rand_mount();
		rd.vx = rand_position();
		rd.vy = rand_position();
		rd.vz = rand_position();
		if ($urandom_range(99) < 80)
			rd.hdg = 16'($urandom);
		else
			rd.hdg = 16'(int'($urandom_range(7)) * 8192 + int'($urandom_range(2)) - 1);
		rd.seen = ($urandom_range(99) < 92);
		rd.now = $urandom;
		pick = $urandom_range(99);
		if (pick < 75)
			rd.ptime = rd.now - 32'($urandom_range(cur_age));
		else if (pick < 85)
			rd.ptime = rd.now - 32'(cur_age) - 32'd1 - 32'($urandom_range(500));
		else if (pick < 95)
			rd.ptime = rd.now + 32'd1 + 32'($urandom_range(1000));
		else
			rd.ptime = $urandom;
		return rd;
	endfunction

	task automatic send_reading(input reading_t rd);
		while (idling_on && $urandom_range(99) < 16) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		sensor_id <= rd.sid;
		range_mm <= rd.dist_mm;
		mount_x_mm <= rd.mx;
		mount_y_mm <= rd.my;
		mount_z_mm <= rd.mz;
		vehicle_x_mm <= rd.vx;
		vehicle_y_mm <= rd.vy;
		vehicle_z_mm <= rd.vz;
		heading <= rd.hdg;
		pose_seen <= rd.seen;
		now_ms <= rd.now;
		pose_time_ms <= rd.ptime;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		readings_sent++;
	endtask

	task automatic random_burst(input int count);
		repeat (count)
			send_reading(random_reading());
	endtask

	// Rejected readings leave no trace in the checker, so the task still waits
	// after the last point, to let them leave the pipeline before any write.
	task automatic drain_pipeline();
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES)
			@(posedge clk);
	endtask

	task automatic program_window(input logic [15:0] lo, input logic [15:0] hi,
			input logic [15:0] age_lim);
		cfg_we <= 1'b1;
		cfg_index <= REG_RANGE_MIN;
		cfg_data <= lo;
		@(posedge clk);
		cfg_index <= REG_RANGE_MAX;
		cfg_data <= hi;
		@(posedge clk);
		cfg_index <= REG_MAX_AGE;
		cfg_data <= age_lim;
		@(posedge clk);
		cfg_we <= 1'b0;
		cur_min = lo;
		cur_max = hi;
		cur_age = age_lim;
		windows_run++;
	endtask

	initial begin
		reading_t rd;
		int s;
		arst_n <= 1'b0;
		cfg_we <= 1'b0;
		cfg_index <= REG_RANGE_MIN;
		cfg_data <= '0;
		in_valid <= 1'b0;
		sensor_id <= '0;
		range_mm <= '0;
		mount_x_mm <= '0;
		mount_y_mm <= '0;
		mount_z_mm <= '0;
		vehicle_x_mm <= '0;
		vehicle_y_mm <= '0;
		vehicle_z_mm <= '0;
		heading <= '0;
		pose_seen <= 1'b0;
		now_ms <= '0;
		pose_time_ms <= '0;
		repeat (6)
			@(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Every sensor id, including the three unknown ones, each at its own octant heading.
		for (s = 0; s < 8; s++) begin
			rd = nominal(3'(s), 16'd1000);
			rd.hdg = 16'(s * 8192);
			rd.mx = 16'sd150;
			rd.my = -16'sd75;
			rd.mz = 16'sd40;
			send_reading(rd);
		end
		send_reading(nominal(SENSOR_FRONT, 16'd0));
		send_reading(nominal(SENSOR_BACK, RANGE_MAX_RST));
		send_reading(nominal(SENSOR_LEFT, RANGE_MAX_RST + 16'd1));
		rd = nominal(SENSOR_RIGHT, 16'd500);
		rd.seen = 1'b0;
		send_reading(rd);
		rd = nominal(SENSOR_UP, 16'd500);
		rd.now = 32'd1200;
		rd.ptime = 32'd1000;
		send_reading(rd);
		rd.ptime = 32'd999;
		send_reading(rd);
		rd = nominal(SENSOR_FRONT, 16'd700);
		rd.ptime = 32'd5000;
		send_reading(rd);
		rd.now = 32'd5;
		rd.ptime = 32'hFFFF_FFF0;
		send_reading(rd);
		rd.now = 32'hFFFF_FFFF;
		rd.ptime = 32'hFFFF_FFFF;
		rd.hdg = 16'h7FFF;
		send_reading(rd);
		rd = nominal(SENSOR_LEFT, 16'd3000);
		rd.hdg = 16'h8000;
		send_reading(rd);
		rd = nominal(SENSOR_FRONT, RANGE_MAX_RST);
		rd.vx = 24'sh7FFFFF;
		send_reading(rd);
		rd = nominal(SENSOR_RIGHT, RANGE_MAX_RST);
		rd.vy = 24'sh800000;
		send_reading(rd);
		rd = nominal(SENSOR_UP, RANGE_MAX_RST);
		rd.vz = 24'sh7FFFFF;
		send_reading(rd);
		rd = nominal(SENSOR_BACK, RANGE_MAX_RST);
		rd.vx = 24'sh800000;
		rd.vz = 24'sh800000;
		send_reading(rd);
		rd = nominal(SENSOR_FRONT, RANGE_MAX_RST);
		rd.mx = 16'sh8000;
		rd.my = 16'sh7FFF;
		rd.mz = 16'sh8000;
		rd.hdg = 16'h4000;
		send_reading(rd);
		random_burst(80);
		drain_pipeline();

		program_window(16'd0, 16'hFFFF, 16'hFFFF);
		idling_on <= 1'b0;
		random_burst(80);
		drain_pipeline();
		idling_on <= 1'b1;

		program_window(16'd0, 16'd0, 16'd0);
		random_burst(50);
		drain_pipeline();

		program_window(16'd5000, 16'd100, 16'd1000);
		random_burst(40);
		drain_pipeline();

		program_window(16'd250, 16'd3000, 16'd100);
		random_burst(80);
		drain_pipeline();

		program_window(16'hFFFF, 16'hFFFF, 16'hFFFF);
		random_burst(40);
		drain_pipeline();

		$display("Sent %0d readings across %0d range and age window settings.",
			readings_sent, windows_run);
		$display("Checked %0d world points: %0d mismatches, %0d points never arrived.",
			points_checked, fail_count, pending);
		if (fail_count == 0 && pending == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule

// ----- sim.f -----
rtl/core/rrwp_pkg.sv
rtl/core/rrwp_cordic.sv
rtl/core/range_ray_to_world_point.sv
dv/world_point_checker.sv
dv/tb_range_ray_to_world_point.sv
